// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define PS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Condition that must never hold.
`define PS_NEVER(label, cond) \
  `PS_ASSERT(label, !(cond))

`endif

// ===== hdl/ps_pkg.sv =====
// Package: types and constants of the percentile selector.
`timescale 1ns / 1ps
package ps_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int FRAC_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRACTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED   = 2'd1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last_sample;
  } in_beat_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] selected;
    logic [CNT_W-1:0]       frame_count;
    logic                   overflowed;
  } out_beat_t;

  typedef enum logic [4:0] {
    ST_LOAD   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DRAIN  = 5'b00100,
    ST_DECIDE = 5'b01000,
    ST_OUT    = 5'b10000
  } state_e;

  typedef struct packed {
    logic load;    // input beat accepted
    logic start;   // accepted beat ends the frame
    logic scan;    // issue one store read
    logic decide;  // settle one key bit
  } dp_cmd_t;

  typedef struct packed {
    logic last_addr;
    logic last_bit;
  } dp_stat_t;

endpackage

// ===== hdl/ps_datapath.sv =====
// Datapath: sample store, configuration, bitwise rank search.
`timescale 1ns / 1ps
module ps_datapath import ps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  input  in_beat_t              in_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output out_beat_t             out_data_o
);

  logic [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
  logic [SAMPLE_BITS-1:0] rdata_q;
  logic                   rd_v_q;

  logic [FRAC_W-1:0]      frac_q;
  logic                   sgn_q;
  logic [CNT_W-1:0]       fill_q, n_q, cnt_q, k_q;
  logic                   ovf_q;
  logic [ADDR_W-1:0]      addr_q;
  logic [SAMPLE_BITS-1:0] bit_q, mask_q, prefix_q, sign_m;
  out_beat_t              out_q;

  logic                   has_room;
  logic [CNT_W-1:0]       n_d;
  logic [FRAC_W+CNT_W-1:0] prod;
  logic [SAMPLE_BITS-1:0] key, prefix_d;
  logic                   hit, go_one;

  assign has_room = fill_q < CNT_W'(MAX_SAMPLES);
  assign n_d      = has_room ? fill_q + CNT_W'(1) : fill_q;
  assign prod     = {{CNT_W{1'b0}}, frac_q} * {{FRAC_W{1'b0}}, n_d};
  assign sign_m   = {sgn_q, {(SAMPLE_BITS-1){1'b0}}};
  assign key      = rdata_q ^ sign_m;
  assign hit      = (((key ^ prefix_q) & mask_q) == '0) && ((key & bit_q) == '0);
  assign go_one   = k_q >= cnt_q;
  assign prefix_d = go_one ? (prefix_q | bit_q) : prefix_q;

  assign stat_o.last_addr = {1'b0, addr_q} == (n_q - CNT_W'(1));
  assign stat_o.last_bit  = bit_q[0];
  assign out_data_o       = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && has_room) begin
      mem[fill_q[ADDR_W-1:0]] <= in_data_i.sample;
    end
    if (cmd_i.scan) begin
      rdata_q <= mem[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q   <= FRAC_W'(32768);
      sgn_q    <= 1'b0;
      fill_q   <= '0;
      ovf_q    <= 1'b0;
      rd_v_q   <= 1'b0;
      addr_q   <= '0;
      cnt_q    <= '0;
      n_q      <= CNT_W'(1);
      k_q      <= '0;
      bit_q    <= '0;
      mask_q   <= '0;
      prefix_q <= '0;
      out_q    <= '0;
    end else begin
      rd_v_q <= cmd_i.scan;
      if (cfg_we_i && cfg_idx_i == CFG_FRACTION) frac_q <= cfg_data_i[FRAC_W-1:0];
      if (cfg_we_i && cfg_idx_i == CFG_SIGNED)   sgn_q  <= cfg_data_i[0];
      if (cmd_i.load) begin
        if (cmd_i.start) begin
          fill_q        <= '0;
          ovf_q         <= 1'b0;
          n_q           <= n_d;
          k_q           <= prod[FRAC_W +: CNT_W];
          out_q.overflowed  <= ovf_q | ~has_room;
          out_q.frame_count <= n_d;
          addr_q   <= '0;
          cnt_q    <= '0;
          bit_q    <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
          mask_q   <= '0;
          prefix_q <= '0;
        end else begin
          fill_q <= n_d;
          ovf_q  <= ovf_q | ~has_room;
        end
      end
      if (cmd_i.scan) begin
        addr_q <= stat_o.last_addr ? '0 : addr_q + ADDR_W'(1);
      end
      if (rd_v_q && hit) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.decide) begin
        if (go_one) k_q <= k_q - cnt_q;
        prefix_q <= prefix_d;
        mask_q   <= mask_q | bit_q;
        bit_q    <= bit_q >> 1;
        cnt_q    <= '0;
        if (bit_q[0]) out_q.selected <= prefix_d ^ sign_m;
      end
    end
  end

endmodule

// ===== hdl/ps_ctrl.sv =====
// Controller: frame load, scan passes per key bit, result beat.
`timescale 1ns / 1ps
module ps_ctrl import ps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  state_e state_q, state_d;
  logic   acc;

  assign in_stall_o  = state_q != ST_LOAD;
  assign out_valid_o = state_q == ST_OUT;
  assign acc         = in_valid_i && !in_stall_o;

  assign cmd_o.load   = acc;
  assign cmd_o.start  = acc && in_last_i;
  assign cmd_o.scan   = state_q == ST_SCAN;
  assign cmd_o.decide = state_q == ST_DECIDE;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:   if (acc && in_last_i) state_d = ST_SCAN;
      ST_SCAN:   if (stat_i.last_addr) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_DECIDE;
      ST_DECIDE: state_d = stat_i.last_bit ? ST_OUT : ST_SCAN;
      ST_OUT:    if (!out_stall_i) state_d = ST_LOAD;
      default:   state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/percentile_select_top.sv =====
// Top level of the percentile selector.
//  channel | dir | handshake           | beat
//  in      | in  | in_valid_i/in_stall_o   | in_beat_t (sample, last_sample)
//  out     | out | out_valid_o/out_stall_i | out_beat_t (selected, count, overflow)
//  cfg     | in  | cfg_we_i            | cfg_idx_i, cfg_data_i
// An accepted beat is stored if there is room. A last beat adds 16 scans of the
// store (one read port, one sample per cycle), then the result beat.
// Input stalls from the last beat until the result beat is taken.
// Reset clears frame count and overflow; store contents are not cleared.
`timescale 1ns / 1ps
module percentile_select_top import ps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_beat_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_beat_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ps_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i,
    .in_last_i (in_data_i.last_sample),
    .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o (cmd), .stat_i (stat)
  );

  ps_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i (cmd), .stat_o (stat),
    .in_data_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .out_data_o
  );

endmodule

// ===== hdl/ps_checker.sv =====
// Port-level checker for the percentile selector, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ps_checker import ps_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input in_beat_t              in_data_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input out_beat_t             out_data_o,
  input logic                  cfg_we_i
);

  `PS_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
  `PS_NEVER(a_no_in_during_out, out_valid_o && !in_stall_o)
  `PS_NEVER(a_count_nonzero, out_valid_o && out_data_o.frame_count == '0)
  `PS_ASSERT(a_search_delay, in_valid_i && !in_stall_o && in_data_i.last_sample |=> !out_valid_o && in_stall_o)
  `PS_NEVER(a_cfg_idle, cfg_we_i && in_stall_o)

endmodule

bind percentile_select_top ps_checker u_chk (.*);

// ===== test/tb.sv =====
// Testbench for percentile_select_top: directed and random frames, checked against a predictor.
`timescale 1ns / 1ps
module tb;
  import ps_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [15:0] FRAC_MEDIAN = 16'h8000;
  localparam logic [15:0] FRAC_FULL   = 16'hFFFF;
  localparam int WATCHDOG_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_beat = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_beat;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_FRACTION;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  percentile_select_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_beat),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_beat),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [SAMPLE_BITS-1:0] frame_store [MAX_SAMPLES];
  int unsigned frame_fill;
  bit frame_dropped;
  logic [15:0] rank_fraction;
  bit order_signed;

  out_beat_t expected_q[$];
  int mismatches = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int frames_sent = 0;
  bit idling_on = 1'b1;
  bit in_accept_seen;
  int quiet_cycles = 0;

  function automatic logic [SAMPLE_BITS-1:0] rank_pick(int n, int k, bit sgn);
    logic [SAMPLE_BITS-1:0] flip;
    int keys[$];
    flip = sgn ? 16'h8000 : 16'h0000;
    for (int i = 0; i < n; i++) keys.push_back(int'(frame_store[i] ^ flip));
    keys.sort();
    return SAMPLE_BITS'(keys[k]) ^ flip;
  endfunction

  task automatic predict_beat(in_beat_t b);
    out_beat_t r;
    int unsigned rank;
    if (frame_fill < MAX_SAMPLES) begin
      frame_store[frame_fill] = b.sample;
      frame_fill++;
    end else begin
      frame_dropped = 1'b1;
    end
    if (b.last_sample) begin
      rank = (rank_fraction * frame_fill) >> 16;
      if (rank >= frame_fill) rank = frame_fill - 1;
      r.selected = rank_pick(frame_fill, rank, order_signed);
      r.frame_count = CNT_W'(frame_fill);
      r.overflowed = frame_dropped;
      expected_q.push_back(r);
      frame_fill = 0;
      frame_dropped = 1'b0;
      frames_sent++;
    end
  endtask

  task automatic send_beat(logic [15:0] s, bit last);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_beat <= '{sample: s, last_sample: last};
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    beats_sent++;
    predict_beat('{sample: s, last_sample: last});
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRACTION) rank_fraction = val;
    else if (idx == CFG_SIGNED) order_signed = val[0];
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_frame(logic [15:0] vals[$]);
    foreach (vals[i]) send_beat(vals[i], i == vals.size() - 1);
  endtask

  task automatic test_extremes();
    send_frame('{16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0001});
    send_frame('{16'h1234});
    drain();
    write_reg(CFG_SIGNED, 16'h0001);
    send_frame('{16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0001});
    drain();
    write_reg(CFG_FRACTION, 16'h0000);
    send_frame('{16'h0005, 16'hFFF0, 16'h0003});
    drain();
    write_reg(CFG_FRACTION, FRAC_FULL);
    send_frame('{16'h0005, 16'hFFF0, 16'h0003, 16'h8000});
    drain();
    write_reg(CFG_SIGNED, 16'hFFFE);  // masks to unsigned
    write_reg(CFG_UNUSED, 16'h0000);  // ignored
    send_frame('{16'h0007, 16'h0007, 16'h0002, 16'h0007});
    drain();
  endtask

  task automatic test_mid_frame_config();
    write_reg(CFG_FRACTION, FRAC_MEDIAN);
    send_beat(16'h8001, 1'b0);
    send_beat(16'h0002, 1'b0);
    send_beat(16'h7FFE, 1'b0);
    drain();
    write_reg(CFG_SIGNED, 16'h0001);
    write_reg(CFG_FRACTION, 16'h4000);
    send_beat(16'hC000, 1'b1);
    drain();
  endtask

  task automatic test_random_frames();
    int len;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_reg(CFG_FRACTION, 16'h0000);
        1: write_reg(CFG_FRACTION, FRAC_FULL);
        2: write_reg(CFG_FRACTION, FRAC_MEDIAN);
        default: write_reg(CFG_FRACTION, 16'($urandom_range(0, 65535)));
      endcase
      write_reg(CFG_SIGNED, 16'($urandom_range(0, 1)));
      if (phase == 5) idling_on = 1'b0;
      for (int done = 0; done < 100; done += len) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) send_beat(rand_sample(), i == len - 1);
      end
      drain();
    end
  endtask

  // result stall bursts
  initial begin
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
        @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    in_accept_seen = in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_beat);
      end else begin
        out_beat_t e;
        e = expected_q.pop_front();
        if (out_beat.selected !== e.selected || out_beat.frame_count !== e.frame_count ||
            out_beat.overflowed !== e.overflowed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected sel=%h cnt=%0d ovf=%b, got sel=%h cnt=%0d ovf=%b",
                     results_seen, e.selected, e.frame_count, e.overflowed,
                     out_beat.selected, out_beat.frame_count, out_beat.overflowed);
        end
      end
    end
    if (!rst_n || in_accept_seen || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    frame_fill = 0;
    frame_dropped = 1'b0;
    rank_fraction = FRAC_MEDIAN;
    order_signed = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_mid_frame_config();
    test_random_frames();
    repeat (50) @(posedge clk);
    $display("sent %0d sample beats in %0d frames, checked %0d results", beats_sent,
             frames_sent, results_seen);
    $display("covered signed/unsigned order, fraction extremes, duplicate values");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ps_pkg.sv
hdl/ps_datapath.sv
hdl/ps_ctrl.sv
hdl/percentile_select_top.sv
hdl/ps_checker.sv
test/tb.sv
